[rtl/core/vld_pkg.sv]
package vld_pkg;

    // Item kinds carried in the slave-side tuser
    typedef enum logic [1:0] {
        CMD_TX_SAMPLE   = 2'd0,
        CMD_IDLE_SAMPLE = 2'd1,
        CMD_TICK        = 2'd2,
        CMD_RX_TICK     = 2'd3
    } vld_cmd_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_DC_OFFSET     = 2'd0,
        CFG_VOX_THRESHOLD = 2'd1,
        CFG_VOX_HOLD      = 2'd2
    } vld_cfg_idx_t;

    localparam int unsigned RAW_W    = 12;
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned LEVEL_W  = 16;
    localparam int unsigned THR_W    = 10;
    localparam int unsigned HOLD_W   = 8;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned CFG_IDX_W = 2;

    // Level is compared in units of 64
    localparam int unsigned LEVEL_SHIFT = 6;

    localparam logic [SAMPLE_W-1:0] DC_OFFSET_RST     = 16'd29760;
    localparam logic [THR_W-1:0]    VOX_THRESHOLD_RST = 10'd10;
    localparam logic [HOLD_W-1:0]   VOX_HOLD_RST      = 8'd10;

    // Peak level never exceeds a full-scale magnitude
    localparam logic [LEVEL_W-1:0]  LEVEL_MAX = 16'd32768;

    typedef struct packed {
        logic [SAMPLE_W-1:0] dc_offset;
        logic [THR_W-1:0]    vox_threshold;
        logic [HOLD_W-1:0]   vox_hold;
    } vld_cfg_t;

endpackage

[rtl/core/vld_cfg_regs.sv]
module vld_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [vld_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [vld_pkg::CFG_W-1:0]         cfg_wdata,
    output vld_pkg::vld_cfg_t                 cfg
);

    vld_pkg::vld_cfg_t cfg_reg;
    vld_pkg::vld_cfg_t cfg_next;

    // Decode the write; unknown indexes leave everything as is
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (vld_pkg::vld_cfg_idx_t'(cfg_addr))
                vld_pkg::CFG_DC_OFFSET:
                    cfg_next.dc_offset = cfg_wdata;
                vld_pkg::CFG_VOX_THRESHOLD:
                    cfg_next.vox_threshold = cfg_wdata[vld_pkg::THR_W-1:0];
                vld_pkg::CFG_VOX_HOLD:
                    cfg_next.vox_hold = cfg_wdata[vld_pkg::HOLD_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dc_offset     <= vld_pkg::DC_OFFSET_RST;
            cfg_reg.vox_threshold <= vld_pkg::VOX_THRESHOLD_RST;
            cfg_reg.vox_hold      <= vld_pkg::VOX_HOLD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/core/vld_level_track.sv]
module vld_level_track (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              advance,
    input  vld_pkg::vld_cmd_t                 cmd,
    input  logic [vld_pkg::RAW_W-1:0]         raw_sample,
    input  logic [vld_pkg::SAMPLE_W-1:0]      dc_offset,
    output logic signed [vld_pkg::SAMPLE_W-1:0] centred_sample,
    output logic [vld_pkg::LEVEL_W-1:0]       level,
    output logic [vld_pkg::LEVEL_W-1:0]       level_next
);

    localparam int unsigned ATT_W = vld_pkg::LEVEL_W + 8;
    localparam int unsigned DEC_W = vld_pkg::LEVEL_W + 14;

    logic [vld_pkg::LEVEL_W-1:0]  level_acc_reg;
    logic [vld_pkg::LEVEL_W-1:0]  level_acc_next;
    logic [vld_pkg::SAMPLE_W-1:0] centred;
    logic [vld_pkg::LEVEL_W-1:0]  mag;
    logic [ATT_W-1:0]             attack_sum;
    logic [DEC_W-1:0]             decay_prod;
    logic                         is_sample;
    logic                         use_decay;

    assign is_sample = (cmd == vld_pkg::CMD_TX_SAMPLE) || (cmd == vld_pkg::CMD_IDLE_SAMPLE);

    // Scale reading to 16 bits and remove the DC offset, wrapping around.
    // The difference is not clamped, so it can wrap when the reading lies far from the offset.
    assign centred = {raw_sample, 4'b0000} - dc_offset;

    // Magnitude; the most negative sample gives 32768, which still fits
    assign mag = centred[vld_pkg::SAMPLE_W-1] ? (~centred + 16'd1) : centred;

    // Attack/average: (L*255 + x) >> 8, decay: (L*16383) >> 14
    assign attack_sum = {level_acc_reg, 8'b0} - ATT_W'(level_acc_reg) + ATT_W'(mag);
    assign decay_prod = {level_acc_reg, 14'b0} - DEC_W'(level_acc_reg);

    assign use_decay = (cmd == vld_pkg::CMD_TX_SAMPLE) && (mag <= level_acc_reg);

    always_comb
    begin
        level_acc_next = level_acc_reg;
        if (is_sample)
        begin
            if (use_decay)
                level_acc_next = decay_prod[DEC_W-1:14];
            else
                level_acc_next = attack_sum[ATT_W-1:8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            level_acc_reg <= '0;
        else if (advance)
            level_acc_reg <= level_acc_next;
    end

    assign centred_sample = is_sample ? $signed(centred) : '0;
    assign level          = level_acc_reg;
    assign level_next     = level_acc_next;

endmodule

[rtl/core/vld_vox_hold.sv]
module vld_vox_hold (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              advance,
    input  vld_pkg::vld_cmd_t                 cmd,
    input  logic [vld_pkg::LEVEL_W-1:0]       level,
    input  vld_pkg::vld_cfg_t                 cfg,
    output logic                              voice_next
);

    logic [vld_pkg::HOLD_W-1:0] hold_count_reg;
    logic [vld_pkg::HOLD_W-1:0] hold_count_next;
    logic                       voice_flag_reg;
    logic                       voice_flag_next;
    logic [vld_pkg::THR_W-1:0]  level_scaled;
    logic                       voice_present;

    assign level_scaled  = level[vld_pkg::LEVEL_W-1:vld_pkg::LEVEL_SHIFT];
    assign voice_present = level_scaled > cfg.vox_threshold;

    // Hysteresis: count up to the hold while voice is present, drain while absent
    always_comb
    begin
        hold_count_next = hold_count_reg;
        voice_flag_next = voice_flag_reg;
        unique case (cmd)
            vld_pkg::CMD_TICK:
            begin
                if (voice_present)
                begin
                    if (hold_count_reg < cfg.vox_hold)
                        hold_count_next = hold_count_reg + 8'd1;
                    else
                        voice_flag_next = 1'b1;
                end
                else
                begin
                    if (hold_count_reg != '0)
                        hold_count_next = hold_count_reg - 8'd1;
                    else
                        voice_flag_next = 1'b0;
                end
            end
            vld_pkg::CMD_RX_TICK:
                voice_flag_next = 1'b0;
            default:
            begin
                hold_count_next = hold_count_reg;
                voice_flag_next = voice_flag_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_count_reg <= '0;
            voice_flag_reg <= 1'b0;
        end
        else if (advance)
        begin
            hold_count_reg <= hold_count_next;
            voice_flag_reg <= voice_flag_next;
        end
    end

    assign voice_next = voice_flag_next;

endmodule

[rtl/core/vox_level_detector_top.sv]
// Voice-operated switch with peak level meter.
//
// Slave stream: s_tuser carries the item kind (transmit sample, idle sample,
// tick, tick while receiving), s_tdata carries the 12-bit converter reading.
// Master stream: one result per input item with the centred sample, the
// tracked level and the switch state after that item.
// Configuration: write cfg_wdata to register cfg_addr while cfg_we is high
// (0 dc offset, 1 threshold, 2 hold); write only while the block is idle.
//
// Data path: an accepted item is loaded into the input register and moves
// into the result register, raising m_tvalid, once that register is free or
// is being read. One item per cycle is sustained while the receiver does not
// stall; the level and hold state are computed from the input register and
// update as the item moves into the result register.
//
// Reset clears level, hold counter and switch, loads the register defaults
// and empties both stages. When the receiver stalls, the result register
// holds and the input register keeps one more item; s_tready drops only
// when both are full.
module vox_level_detector_top (
    input  logic        clk,
    input  logic        rst_n,
    // Slave stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] raw_sample, [15:12] zero
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    // Master stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [15:0] centred_sample, [31:16] level,
                                   // [32] voice_on, [39:33] zero
    // Configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    vld_pkg::vld_cfg_t                    cfg;
    logic                                 in_valid_reg;
    vld_pkg::vld_cmd_t                    in_cmd_reg;
    logic [vld_pkg::RAW_W-1:0]            in_raw_reg;
    logic                                 out_valid_reg;
    logic [vld_pkg::SAMPLE_W-1:0]         out_centred_reg;
    logic [vld_pkg::LEVEL_W-1:0]          out_level_reg;
    logic                                 out_voice_reg;
    logic                                 advance;
    logic signed [vld_pkg::SAMPLE_W-1:0]  centred_sample;
    logic [vld_pkg::LEVEL_W-1:0]          level;
    logic [vld_pkg::LEVEL_W-1:0]          level_next;
    logic                                 voice_next;

    // Move the input register into the result register when it is free or being read
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    vld_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    vld_level_track u_level (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .cmd            (in_cmd_reg),
        .raw_sample     (in_raw_reg),
        .dc_offset      (cfg.dc_offset),
        .centred_sample (centred_sample),
        .level          (level),
        .level_next     (level_next)
    );

    vld_vox_hold u_vox (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .cmd        (in_cmd_reg),
        .level      (level),
        .cfg        (cfg),
        .voice_next (voice_next)
    );

    // Input register: capture on every slave transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_cmd_reg <= vld_pkg::vld_cmd_t'(s_tuser);
            in_raw_reg <= s_tdata[vld_pkg::RAW_W-1:0];
        end
    end

    // Result register: load on advance, drop after a master transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_centred_reg <= centred_sample;
            out_level_reg   <= level_next;
            out_voice_reg   <= voice_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_voice_reg, out_level_reg, out_centred_reg};

    // The tracked level stays within full-scale magnitude
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[31:16] <= vld_pkg::LEVEL_MAX))
        else $error("level above full scale");

    // A receive tick always turns the switch off
    a_rx_tick_off: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (in_cmd_reg == vld_pkg::CMD_RX_TICK)) |=> (m_tdata[32] == 1'b0))
        else $error("switch on after receive tick");

    // Ticks carry a zero sample
    a_tick_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && ((in_cmd_reg == vld_pkg::CMD_TICK) ||
                     (in_cmd_reg == vld_pkg::CMD_RX_TICK)))
        |=> (m_tdata[15:0] == 16'd0))
        else $error("nonzero sample on tick");

    // Backpressure reaches the slave side only with both stages full
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && m_tvalid && !m_tready))
        else $error("ready low with a free stage");

endmodule
